[design/tasd_pkg.sv]
// Shared types and constants for the token atom stream decoder.
// No dependencies.
package tasd_pkg;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LEN,
    PH_DATA
  } phase_t;

  localparam logic [2:0] TAG_TINY   = 3'd0;
  localparam logic [2:0] TAG_SHORT  = 3'd1;
  localparam logic [2:0] TAG_MEDIUM = 3'd2;
  localparam logic [2:0] TAG_LONG   = 3'd3;
  localparam logic [2:0] TAG_CTRL   = 3'd4;

  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_DATA   = 1'b1;

  localparam int unsigned LEN_BITS = 24;

  typedef struct packed {
    logic                kind;
    logic [2:0]          tag_code;
    logic [7:0]          control_code;
    logic                signed_flag;
    logic                bytes_flag;
    logic [LEN_BITS-1:0] atom_length;
    logic [7:0]          value;
    logic                last;
  } result_t;

endpackage

[design/token_atom_stream_decoder.sv]
// Token atom stream decoder: classifies token header bytes and passes atom data bytes.
// Depends on tasd_pkg.
// A result is registered in the output register, or in the skid register while the output is stalled.
// Throughput: one byte per cycle while in_ready is high; the output register plus a one-entry skid register
// keep input transfers going while a result waits, so in_ready drops only when both are full.
// Reset (rst_n, synchronous, active low): idle, expecting a header, no results pending.
module token_atom_stream_decoder #(
  parameter int unsigned LENGTH_WIDTH = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [2:0]  out_tag_code,
  output logic [7:0]  out_control_code,
  output logic        out_signed_flag,
  output logic        out_bytes_flag,
  output logic [23:0] out_atom_length,
  output logic [7:0]  out_value,
  output logic        out_last
);

  localparam int unsigned LB = tasd_pkg::LEN_BITS;
  localparam logic [LB:0] LenMax = (LB+1)'((1 << LENGTH_WIDTH) - 1);

  tasd_pkg::phase_t          phase_r, phase_nxt;
  logic [1:0]                len_left_r, len_left_nxt;
  logic [LB-1:0]             acc_r, acc_nxt;
  logic [LENGTH_WIDTH-1:0]   data_left_r, data_left_nxt;
  logic [1:0]                tag_r, tag_nxt;
  logic                      sgn_r, sgn_nxt;
  logic                      byt_r, byt_nxt;

  tasd_pkg::result_t         res;
  logic                      res_valid;
  tasd_pkg::result_t         out_r, skid_r;
  logic                      out_valid_r, skid_valid_r;

  logic                      in_fire;
  logic [LB-1:0]             acc_shift;
  logic [1:0]                len_left_dec;
  logic [LB-1:0]             len_raw;
  logic [LB-1:0]             len_sat;
  logic [LENGTH_WIDTH-1:0]   data_left_dec;
  logic                      is_tiny, is_short, is_medium, is_long;

  assign in_ready  = !skid_valid_r;
  assign in_fire   = in_valid && in_ready;

  assign acc_shift     = {acc_r[LB-9:0], in_byte};
  assign len_left_dec  = len_left_r - 2'd1;
  assign data_left_dec = data_left_r - LENGTH_WIDTH'(1);
  assign len_raw       = (phase_r == tasd_pkg::PH_LEN) ? acc_shift
                                                        : LB'(in_byte[3:0]);
  assign len_sat       = ({1'b0, len_raw} > LenMax) ? LenMax[LB-1:0] : len_raw;

  assign is_tiny   = !in_byte[7];
  assign is_short  = in_byte[7:6] == 2'b10;
  assign is_medium = in_byte[7:5] == 3'b110;
  assign is_long   = in_byte[7:2] == 6'b111000;

  // Next state.
  always_comb begin
    phase_nxt     = phase_r;
    len_left_nxt  = len_left_r;
    acc_nxt       = acc_r;
    data_left_nxt = data_left_r;
    tag_nxt       = tag_r;
    sgn_nxt       = sgn_r;
    byt_nxt       = byt_r;
    if (in_fire) begin
      case (phase_r)
        tasd_pkg::PH_LEN: begin
          acc_nxt      = acc_shift;
          len_left_nxt = len_left_dec;
          if (len_left_dec == 2'd0) begin
            acc_nxt       = len_sat;
            data_left_nxt = len_sat[LENGTH_WIDTH-1:0];
            phase_nxt     = (len_sat == '0) ? tasd_pkg::PH_IDLE : tasd_pkg::PH_DATA;
          end
        end
        tasd_pkg::PH_DATA: begin
          data_left_nxt = data_left_dec;
          if (data_left_dec == '0) begin
            phase_nxt = tasd_pkg::PH_IDLE;
          end
        end
        default: begin
          phase_nxt = tasd_pkg::PH_IDLE;
          if (is_tiny) begin
            tag_nxt = tasd_pkg::TAG_TINY[1:0];
            sgn_nxt = in_byte[6];
            byt_nxt = 1'b0;
          end else if (is_short) begin
            tag_nxt       = tasd_pkg::TAG_SHORT[1:0];
            byt_nxt       = in_byte[5];
            sgn_nxt       = in_byte[4];
            acc_nxt       = len_sat;
            data_left_nxt = len_sat[LENGTH_WIDTH-1:0];
            phase_nxt     = (len_sat == '0) ? tasd_pkg::PH_IDLE : tasd_pkg::PH_DATA;
          end else if (is_medium) begin
            tag_nxt      = tasd_pkg::TAG_MEDIUM[1:0];
            byt_nxt      = in_byte[4];
            sgn_nxt      = in_byte[3];
            acc_nxt      = LB'(in_byte[2:0]);
            len_left_nxt = 2'd1;
            phase_nxt    = tasd_pkg::PH_LEN;
          end else if (is_long) begin
            tag_nxt      = tasd_pkg::TAG_LONG[1:0];
            byt_nxt      = in_byte[1];
            sgn_nxt      = in_byte[0];
            acc_nxt      = '0;
            len_left_nxt = 2'd3;
            phase_nxt    = tasd_pkg::PH_LEN;
          end
        end
      endcase
    end
  end

  // Result of the current transfer.
  always_comb begin
    res       = '0;
    res_valid = 1'b0;
    if (in_fire) begin
      case (phase_r)
        tasd_pkg::PH_LEN: begin
          res_valid        = len_left_dec == 2'd0;
          res.kind         = tasd_pkg::KIND_HEADER;
          res.tag_code     = {1'b0, tag_r};
          res.signed_flag  = sgn_r;
          res.bytes_flag   = byt_r;
          res.atom_length  = len_sat;
          res.last         = len_sat == '0;
        end
        tasd_pkg::PH_DATA: begin
          res_valid        = 1'b1;
          res.kind         = tasd_pkg::KIND_DATA;
          res.tag_code     = {1'b0, tag_r};
          res.signed_flag  = sgn_r;
          res.bytes_flag   = byt_r;
          res.atom_length  = acc_r;
          res.value        = in_byte;
          res.last         = data_left_dec == '0;
        end
        default: begin
          res.kind = tasd_pkg::KIND_HEADER;
          if (is_tiny) begin
            res_valid       = 1'b1;
            res.tag_code    = tasd_pkg::TAG_TINY;
            res.signed_flag = in_byte[6];
            res.value       = {{2{in_byte[6] & in_byte[5]}}, in_byte[5:0]};
            res.last        = 1'b1;
          end else if (is_short) begin
            res_valid       = 1'b1;
            res.tag_code    = tasd_pkg::TAG_SHORT;
            res.bytes_flag  = in_byte[5];
            res.signed_flag = in_byte[4];
            res.atom_length = len_sat;
            res.last        = len_sat == '0;
          end else if (!is_medium && !is_long) begin
            res_valid        = 1'b1;
            res.tag_code     = tasd_pkg::TAG_CTRL;
            res.control_code = in_byte;
            res.last         = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= tasd_pkg::PH_IDLE;
      len_left_r  <= '0;
      acc_r       <= '0;
      data_left_r <= '0;
      tag_r       <= '0;
      sgn_r       <= 1'b0;
      byt_r       <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      len_left_r  <= len_left_nxt;
      acc_r       <= acc_nxt;
      data_left_r <= data_left_nxt;
      tag_r       <= tag_nxt;
      sgn_r       <= sgn_nxt;
      byt_r       <= byt_nxt;
    end
  end

  // Output register with a one-entry skid behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_r        <= skid_r;
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_r       <= res;
        out_valid_r <= res_valid;
      end
    end else if (res_valid) begin
      skid_r       <= res;
      skid_valid_r <= 1'b1;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_r.kind;
  assign out_tag_code     = out_r.tag_code;
  assign out_control_code = out_r.control_code;
  assign out_signed_flag  = out_r.signed_flag;
  assign out_bytes_flag   = out_r.bytes_flag;
  assign out_atom_length  = out_r.atom_length;
  assign out_value        = out_r.value;
  assign out_last         = out_r.last;

endmodule

[bench/tb_token_atom_stream_decoder.sv]
// Self-checking bench for token_atom_stream_decoder: directed and random token streams,
// a cycle-free decode predictor in a scoreboard class, random idling on both channels.
// Depends on tasd_pkg and design/token_atom_stream_decoder.sv.
module tb_token_atom_stream_decoder;

  localparam int unsigned LENGTH_WIDTH = 24;
  localparam logic [23:0] LEN_MAX = 24'((32'd1 << LENGTH_WIDTH) - 32'd1);
  localparam int ITEM_GOAL = 1350;
  localparam int CALM_ITEMS = 120;
  localparam int TAIL_ITEMS = 24;
  localparam int QUIET_LIMIT = 3000;

  class atom_decode_board;
    tasd_pkg::phase_t  ph;
    logic [1:0]        len_left;
    logic [23:0]       len_acc;
    logic [23:0]       data_left;
    logic [2:0]        cur_tag;
    logic              cur_signed;
    logic              cur_bytes;
    tasd_pkg::result_t decoded_due[$];
    int                mismatches;

    function new();
      ph = tasd_pkg::PH_IDLE;
      len_left = '0;
      len_acc = '0;
      data_left = '0;
      cur_tag = tasd_pkg::TAG_TINY;
      cur_signed = 1'b0;
      cur_bytes = 1'b0;
      mismatches = 0;
    endfunction

    function int pending();
      return decoded_due.size();
    endfunction

    function void announce_length(logic [23:0] len);
      tasd_pkg::result_t r;
      if (len > LEN_MAX) len = LEN_MAX;
      len_acc = len;
      data_left = len;
      r = '0;
      r.kind = tasd_pkg::KIND_HEADER;
      r.tag_code = cur_tag;
      r.signed_flag = cur_signed;
      r.bytes_flag = cur_bytes;
      r.atom_length = len;
      r.last = (len == 24'd0);
      decoded_due.push_back(r);
      ph = (len == 24'd0) ? tasd_pkg::PH_IDLE : tasd_pkg::PH_DATA;
    endfunction

    function void note_stream_byte(logic [7:0] b);
      tasd_pkg::result_t r;
      r = '0;
      case (ph)
        tasd_pkg::PH_LEN: begin
          len_acc = {len_acc[15:0], b};
          len_left = len_left - 2'd1;
          if (len_left == 2'd0) announce_length(len_acc);
        end
        tasd_pkg::PH_DATA: begin
          data_left = data_left - 24'd1;
          r.kind = tasd_pkg::KIND_DATA;
          r.tag_code = cur_tag;
          r.signed_flag = cur_signed;
          r.bytes_flag = cur_bytes;
          r.atom_length = len_acc;
          r.value = b;
          r.last = (data_left == 24'd0);
          decoded_due.push_back(r);
          if (data_left == 24'd0) ph = tasd_pkg::PH_IDLE;
        end
        default: begin
          ph = tasd_pkg::PH_IDLE;
          if (!b[7]) begin
            cur_tag = tasd_pkg::TAG_TINY;
            cur_signed = b[6];
            cur_bytes = 1'b0;
            r.kind = tasd_pkg::KIND_HEADER;
            r.tag_code = tasd_pkg::TAG_TINY;
            r.signed_flag = b[6];
            r.value = (b[6] && b[5]) ? {2'b11, b[5:0]} : {2'b00, b[5:0]};
            r.last = 1'b1;
            decoded_due.push_back(r);
          end else if (b[7:6] == 2'b10) begin
            cur_tag = tasd_pkg::TAG_SHORT;
            cur_bytes = b[5];
            cur_signed = b[4];
            announce_length({20'd0, b[3:0]});
          end else if (b[7:5] == 3'b110) begin
            cur_tag = tasd_pkg::TAG_MEDIUM;
            cur_bytes = b[4];
            cur_signed = b[3];
            len_acc = {21'd0, b[2:0]};
            len_left = 2'd1;
            ph = tasd_pkg::PH_LEN;
          end else if (b[7:2] == 6'b111000) begin
            cur_tag = tasd_pkg::TAG_LONG;
            cur_bytes = b[1];
            cur_signed = b[0];
            len_acc = '0;
            len_left = 2'd3;
            ph = tasd_pkg::PH_LEN;
          end else begin
            r.kind = tasd_pkg::KIND_HEADER;
            r.tag_code = tasd_pkg::TAG_CTRL;
            r.control_code = b;
            r.last = 1'b1;
            decoded_due.push_back(r);
          end
        end
      endcase
    endfunction

    function void check_decoded(tasd_pkg::result_t got);
      tasd_pkg::result_t want;
      bit                bad;
      if (decoded_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind=%0d tag=%0d ctrl=%02h len=%06h val=%02h last=%0d",
                   got.kind, got.tag_code, got.control_code, got.atom_length, got.value,
                   got.last);
        return;
      end
      want = decoded_due.pop_front();
      bad = (got.kind !== want.kind) || (got.tag_code !== want.tag_code) ||
            (got.control_code !== want.control_code) ||
            (got.signed_flag !== want.signed_flag) ||
            (got.bytes_flag !== want.bytes_flag) ||
            (got.atom_length !== want.atom_length) ||
            (got.value !== want.value) || (got.last !== want.last);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("exp: kind=%0d tag=%0d ctrl=%02h sgn=%0d byt=%0d len=%06h val=%02h last=%0d",
                   want.kind, want.tag_code, want.control_code, want.signed_flag,
                   want.bytes_flag, want.atom_length, want.value, want.last);
          $display("got: kind=%0d tag=%0d ctrl=%02h sgn=%0d byt=%0d len=%06h val=%02h last=%0d",
                   got.kind, got.tag_code, got.control_code, got.signed_flag,
                   got.bytes_flag, got.atom_length, got.value, got.last);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_kind;
  logic [2:0]  out_tag_code;
  logic [7:0]  out_control_code;
  logic        out_signed_flag;
  logic        out_bytes_flag;
  logic [23:0] out_atom_length;
  logic [7:0]  out_value;
  logic        out_last;

  atom_decode_board sb = new();
  bit calm = 1'b0;
  int in_gap_pct = 10;
  int out_stall_pct = 10;
  int hold_left = 0;
  int quiet_cycles = 0;
  int items_sent = 0;

  token_atom_stream_decoder #(
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_tag_code     (out_tag_code),
    .out_control_code (out_control_code),
    .out_signed_flag  (out_signed_flag),
    .out_bytes_flag   (out_bytes_flag),
    .out_atom_length  (out_atom_length),
    .out_value        (out_value),
    .out_last         (out_last)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_decoded(tasd_pkg::result_t'({out_kind, out_tag_code, out_control_code,
                                            out_signed_flag, out_bytes_flag,
                                            out_atom_length, out_value, out_last}));
    if (calm) begin
      out_ready <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < out_stall_pct) begin
      hold_left = $urandom_range(0, 12);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < in_gap_pct) gap = $urandom_range(1, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_stream_byte(b);
    items_sent++;
  endtask

  task automatic send_data(input int unsigned n);
    repeat (n) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic send_random_token();
    int          pick;
    logic [7:0]  hdr;
    logic [2:0]  hi;
    logic [7:0]  lo;
    logic [7:0]  mid;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      send_byte(8'($urandom_range(0, 127)));
    end else if (pick < 40) begin
      hdr = 8'($urandom_range(8'h80, 8'hBF));
      send_byte(hdr);
      send_data(32'(hdr[3:0]));
    end else if (pick < 56) begin
      hi = 3'd0;
      lo = 8'($urandom_range(0, 24));
      if ($urandom_range(0, 39) == 0) begin
        hi = 3'($urandom_range(0, 1));
        lo = 8'($urandom_range(0, 255));
      end
      hdr = {3'b110, 2'($urandom_range(0, 3)), hi};
      send_byte(hdr);
      send_byte(lo);
      send_data(32'({hi, lo}));
    end else if (pick < 70) begin
      mid = ($urandom_range(0, 29) == 0) ? 8'd1 : 8'd0;
      lo = ($urandom_range(0, 29) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(0, 24));
      send_byte(8'hE0 | 8'($urandom_range(0, 3)));
      send_byte(8'h00);
      send_byte(mid);
      send_byte(lo);
      send_data(32'({mid, lo}));
    end else if (pick < 80) begin
      send_byte(8'($urandom_range(8'hE4, 8'hFF)));
    end else if (pick < 90) begin
      case ($urandom_range(0, 2))
        0: send_byte({3'b100, 1'($urandom_range(0, 1)), 4'h0} | 8'($urandom_range(0, 1) << 5));
        1: begin
          send_byte({3'b110, 2'($urandom_range(0, 3)), 3'b000});
          send_byte(8'h00);
        end
        default: begin
          send_byte(8'hE0 | 8'($urandom_range(0, 3)));
          repeat (3) send_byte(8'h00);
        end
      endcase
    end else begin
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 5;
      2: return 20;
      default: return 45;
    endcase
  endfunction

  initial begin
    int next_mode_at;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_byte(8'h00);
    send_byte(8'h3F);
    send_byte(8'h40);
    send_byte(8'h7F);
    send_byte(8'h60);
    send_byte(8'h5F);
    send_byte(8'h80);
    send_byte(8'hB0);
    send_byte(8'hBF);
    repeat (7) send_byte(8'hFF);
    repeat (8) send_byte(8'h00);
    send_byte(8'hA1);
    send_byte(8'h55);
    send_byte(8'hC0);
    send_byte(8'h00);
    send_byte(8'hC8);
    send_byte(8'h03);
    send_data(3);
    send_byte(8'hD9);
    send_byte(8'h00);
    send_data(256);
    send_byte(8'hE0);
    repeat (3) send_byte(8'h00);
    send_byte(8'hE1);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h02);
    send_data(2);
    send_byte(8'hE4);
    send_byte(8'hF0);
    send_byte(8'hFB);
    send_byte(8'hFF);

    next_mode_at = items_sent;
    while (items_sent < ITEM_GOAL - CALM_ITEMS - TAIL_ITEMS) begin
      if (items_sent >= next_mode_at) begin
        in_gap_pct = pick_idle_pct();
        out_stall_pct = pick_idle_pct();
        next_mode_at = items_sent + 120;
      end
      send_random_token();
    end

    calm = 1'b1;
    next_mode_at = items_sent + CALM_ITEMS;
    while (items_sent < next_mode_at) send_random_token();
    send_byte(8'hE2);
    repeat (3) send_byte(8'hFF);
    send_data(20);
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
